@@ hdl/pid_pkg.sv @@
// Shared constants and types for the PID controller with integral separation.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pid_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int GAIN_W    = 32;
    localparam int THR_W     = 31;
    localparam int ACC_W     = 48;
    localparam int SUM_W     = ACC_W + 2;
    localparam int LIMB_W    = 24;
    localparam int DMS_W     = 9;
    localparam int DT_MIN_MS = 10;
    localparam int DT_MAX_MS = 500;
    localparam int MS_SHIFT  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P     = 3'd0,
        CFG_GAIN_I     = 3'd1,
        CFG_GAIN_D     = 3'd2,
        CFG_SEP_THR    = 3'd3,
        CFG_LIMIT_HIGH = 3'd4,
        CFG_LIMIT_LOW  = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

@@ hdl/pid_front.sv @@
// Input stage: takes items, forms the error and the clamped time step in Q format.
// Depends on pid_pkg; feeds pid_fifo.
`default_nettype none

module pid_front
    import pid_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [DATA_WIDTH-1:0]  i_setpoint,
    input  logic signed [DATA_WIDTH-1:0]  i_measured,
    input  logic        [31:0]            i_stamp_ms,
    input  t_queue_status                 i_queue,
    output logic                          o_push,
    output logic signed [DATA_WIDTH:0]    o_err,
    output logic        [FRAC_BITS-1:0]   o_dt
);

    localparam int EW = DATA_WIDTH + 1;
    localparam longint unsigned MS_TO_Q =
        ((64'd1 << (FRAC_BITS + MS_SHIFT)) + 64'd500) / 64'd1000;
    localparam int K_W    = FRAC_BITS + 7;
    localparam int PROD_W = DMS_W + K_W + 1;
    localparam int DTF_W  = PROD_W - MS_SHIFT;

    logic                   r_valid;
    logic signed [EW-1:0]   r_err;
    logic [DMS_W-1:0]       r_dms;
    logic [31:0]            r_prev_stamp;

    logic                   accept;
    logic signed [31:0]     stamp_diff;
    logic [DMS_W-1:0]       dms_clamped;
    logic [PROD_W-1:0]      prod;
    logic [DTF_W-1:0]       dt_full;

    assign accept  = i_valid && o_ready;
    assign o_push  = r_valid && !i_queue.full;
    assign o_ready = !r_valid || o_push;

    // A backwards stamp reads as a negative step and lands on the low clamp.
    always_comb begin
        stamp_diff = signed'(i_stamp_ms - r_prev_stamp);
        if (stamp_diff < DT_MIN_MS) begin
            dms_clamped = DMS_W'(DT_MIN_MS);
        end else if (stamp_diff > DT_MAX_MS) begin
            dms_clamped = DMS_W'(DT_MAX_MS);
        end else begin
            dms_clamped = stamp_diff[DMS_W-1:0];
        end
    end

    always_comb begin
        prod    = PROD_W'(r_dms) * PROD_W'(MS_TO_Q) + (PROD_W'(1) << (MS_SHIFT - 1));
        dt_full = prod[PROD_W-1:MS_SHIFT];
        o_dt    = (dt_full == '0) ? FRAC_BITS'(1) : dt_full[FRAC_BITS-1:0];
        o_err   = r_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_prev_stamp <= '0;
        end else begin
            if (accept) begin
                r_valid      <= 1'b1;
                r_prev_stamp <= i_stamp_ms;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_err <= EW'(i_setpoint) - EW'(i_measured);
            r_dms <= dms_clamped;
        end
    end

endmodule

`default_nettype wire

@@ hdl/pid_fifo.sv @@
// Short queue between the input stage and the arithmetic core.
// Depends on pid_pkg for its depth and status type.
`default_nettype none

module pid_fifo
    import pid_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_queue_status    o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_data         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/pid_mulq.sv @@
// Shared fractional multiplier: floor(a*b / 2^FRAC_BITS) saturated to 48 bits.
// The wide operand is taken in two 24-bit limbs. Depends on pid_pkg.
`default_nettype none

module pid_mulq
    import pid_pkg::*;
#(
    parameter int BW        = ACC_W,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [GAIN_W-1:0] i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic                     o_done,
    output logic signed [ACC_W-1:0]  o_res
);

    localparam int HI_W = BW - LIMB_W;
    localparam int MB_W = HI_W + 1;
    localparam int MP_W = GAIN_W + MB_W;
    localparam int PW   = GAIN_W + BW;
    localparam int UP_W = PW - ACC_W + 1;

    typedef enum logic [4:0] {
        MUL_IDLE = 5'b00001,
        MUL_LO   = 5'b00010,
        MUL_HI   = 5'b00100,
        MUL_SAT  = 5'b01000,
        MUL_DONE = 5'b10000
    } t_mul_state;

    t_mul_state              r_state;
    t_mul_state              n_state;
    logic signed [GAIN_W-1:0] r_a;
    logic signed [BW-1:0]     r_b;
    logic signed [PW-1:0]     r_acc;
    logic signed [ACC_W-1:0]  r_res;

    logic signed [MB_W-1:0]  mul_b;
    logic signed [MP_W-1:0]  mul_p;
    logic signed [PW-1:0]    mul_ext;
    logic signed [PW-1:0]    shifted;
    logic [UP_W-1:0]         upper;
    logic signed [ACC_W-1:0] sat_res;

    always_comb begin
        if (r_state == MUL_LO) begin
            mul_b = signed'({{(MB_W - LIMB_W){1'b0}}, r_b[LIMB_W-1:0]});
        end else begin
            mul_b = signed'({r_b[BW-1], r_b[BW-1:LIMB_W]});
        end
        mul_p   = r_a * mul_b;
        mul_ext = PW'(mul_p);
        shifted = r_acc >>> FRAC_BITS;
        upper   = shifted[PW-1:ACC_W-1];
        if ((&upper) || !(|upper)) begin
            sat_res = shifted[ACC_W-1:0];
        end else if (shifted[PW-1]) begin
            sat_res = signed'({1'b1, {(ACC_W-1){1'b0}}});
        end else begin
            sat_res = signed'({1'b0, {(ACC_W-1){1'b1}}});
        end
    end

    always_comb begin
        unique case (r_state)
            MUL_IDLE: n_state = i_start ? MUL_LO : MUL_IDLE;
            MUL_LO:   n_state = MUL_HI;
            MUL_HI:   n_state = MUL_SAT;
            MUL_SAT:  n_state = MUL_DONE;
            MUL_DONE: n_state = MUL_IDLE;
            default:  n_state = MUL_IDLE;
        endcase
    end

    assign o_done = (r_state == MUL_DONE);
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MUL_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == MUL_IDLE && i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_state == MUL_LO) begin
            r_acc <= mul_ext;
        end
        if (r_state == MUL_HI) begin
            r_acc <= r_acc + (mul_ext <<< LIMB_W);
        end
        if (r_state == MUL_SAT) begin
            r_res <= sat_res;
        end
    end

endmodule

`default_nettype wire

@@ hdl/pid_core.sv @@
// Arithmetic core: integral update with separation and anti-windup, derivative
// by a radix-2 divider, P+I+D sum and output clamp. Depends on pid_pkg, pid_mulq.
`default_nettype none

module pid_core
    import pid_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_queue_status                i_queue,
    input  logic signed [DATA_WIDTH:0]   i_err,
    input  logic        [FRAC_BITS-1:0]  i_dt,
    output logic                         o_pop,
    input  logic signed [GAIN_W-1:0]     i_gain_p,
    input  logic signed [GAIN_W-1:0]     i_gain_i,
    input  logic signed [GAIN_W-1:0]     i_gain_d,
    input  logic        [THR_W-1:0]      i_sep_thr,
    input  logic signed [DATA_WIDTH-1:0] i_limit_high,
    input  logic signed [DATA_WIDTH-1:0] i_limit_low,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_drive
);

    localparam int EW     = DATA_WIDTH + 1;
    localparam int DERR_W = DATA_WIDTH + 2;
    localparam int NMAG_W = DATA_WIDTH + 1;
    localparam int NW     = NMAG_W + FRAC_BITS;
    localparam int NWE    = NW + (NW % 2);
    localparam int STEPS  = NWE / 2;
    localparam int CNT_W  = $clog2(STEPS);
    localparam int BW     = (EW > ACC_W) ? EW : ACC_W;
    localparam int QX     = (NWE > ACC_W + 1) ? NWE : ACC_W + 1;
    localparam int CMP_W  = (EW > THR_W) ? EW : THR_W;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_DIV     = 9'b000000010,
        ST_RATE    = 9'b000000100,
        ST_MUL_INT = 9'b000001000,
        ST_MUL_P   = 9'b000010000,
        ST_MUL_I   = 9'b000100000,
        ST_MUL_D   = 9'b001000000,
        ST_FINISH  = 9'b010000000,
        ST_OUT     = 9'b100000000
    } t_core_state;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-ACC_W:0] up;
        up = v[SUM_W-1:ACC_W-1];
        if ((&up) || !(|up)) begin
            return v[ACC_W-1:0];
        end else if (v[SUM_W-1]) begin
            return signed'({1'b1, {(ACC_W-1){1'b0}}});
        end else begin
            return signed'({1'b0, {(ACC_W-1){1'b1}}});
        end
    endfunction

    t_core_state             r_state;
    t_core_state             n_state;
    logic signed [EW-1:0]    r_err;
    logic [FRAC_BITS-1:0]    r_dt;
    logic                    r_inside;
    logic                    r_do_int;
    logic                    r_neg;
    logic [NWE-1:0]          r_num;
    logic [FRAC_BITS-1:0]    r_rem;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [ACC_W-1:0] r_rate;
    logic signed [ACC_W-1:0] r_integral;
    logic signed [EW-1:0]    r_prev_err;
    logic signed [ACC_W-1:0] r_prev_raw;
    logic signed [SUM_W-1:0] r_acc;
    logic                    r_issued;
    logic                    r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_drive;

    logic                    load_item;
    logic                    out_load;
    logic                    div_last;
    logic signed [DERR_W-1:0] derr;
    logic [DERR_W-1:0]       dmag;
    logic [EW-1:0]           aerr;
    logic                    in_band;
    logic                    take;
    logic signed [ACC_W-1:0] lh_ext;
    logic signed [ACC_W-1:0] ll_ext;
    logic [FRAC_BITS:0]      rem_a;
    logic [FRAC_BITS:0]      rem_a2;
    logic [FRAC_BITS:0]      rem_b;
    logic [FRAC_BITS:0]      rem_b2;
    logic                    q_a;
    logic                    q_b;
    logic [QX-1:0]           q_lim;
    logic [QX-1:0]           q_mag;
    logic signed [ACC_W-1:0] rate;
    logic signed [ACC_W-1:0] clamp_hi;
    logic signed [ACC_W-1:0] clamp_lo;
    logic                    mul_start;
    logic                    mul_done;
    logic signed [GAIN_W-1:0] mul_a;
    logic signed [BW-1:0]    mul_b;
    logic signed [ACC_W-1:0] mul_res;
    logic                    in_mul;

    assign lh_ext    = ACC_W'(i_limit_high);
    assign ll_ext    = ACC_W'(i_limit_low);
    assign load_item = (r_state == ST_IDLE) && !i_queue.empty;
    assign o_pop     = load_item;
    assign out_load  = (r_state == ST_OUT) && (!r_out_valid || i_ready);
    assign div_last  = (r_cnt == CNT_W'(STEPS - 1));
    assign in_mul    = (r_state == ST_MUL_INT) || (r_state == ST_MUL_P) ||
                       (r_state == ST_MUL_I) || (r_state == ST_MUL_D);
    assign mul_start = in_mul && !r_issued;
    assign o_valid   = r_out_valid;
    assign o_drive   = r_drive;

    // Classification of a new item against the state left by the previous one.
    always_comb begin
        derr = DERR_W'(i_err) - DERR_W'(r_prev_err);
        dmag = derr[DERR_W-1] ? DERR_W'(-derr) : DERR_W'(derr);
        aerr = i_err[EW-1] ? EW'(-i_err) : EW'(i_err);
        in_band = CMP_W'(aerr) < CMP_W'(i_sep_thr);
        if (r_prev_raw >= lh_ext) begin
            take = i_err[EW-1];
        end else if (r_prev_raw <= ll_ext) begin
            take = !i_err[EW-1] && (i_err != '0);
        end else begin
            take = 1'b1;
        end
    end

    // Two restoring division steps per cycle on |derr| * 2^FRAC_BITS.
    always_comb begin
        rem_a  = {r_rem, r_num[NWE-1]};
        q_a    = rem_a >= {1'b0, r_dt};
        rem_a2 = q_a ? rem_a - {1'b0, r_dt} : rem_a;
        rem_b  = {rem_a2[FRAC_BITS-1:0], r_num[NWE-2]};
        q_b    = rem_b >= {1'b0, r_dt};
        rem_b2 = q_b ? rem_b - {1'b0, r_dt} : rem_b;
    end

    always_comb begin
        q_lim = (QX'(1) << (ACC_W - 1)) - (r_neg ? QX'(0) : QX'(1));
        q_mag = (QX'(r_num) > q_lim) ? q_lim : QX'(r_num);
        rate  = r_neg ? ACC_W'(-q_mag) : ACC_W'(q_mag);
        clamp_hi = (r_prev_raw > lh_ext) ? lh_ext : r_prev_raw;
        clamp_lo = (clamp_hi < ll_ext) ? ll_ext : clamp_hi;
    end

    always_comb begin
        unique case (r_state)
            ST_MUL_INT: begin
                mul_a = signed'(GAIN_W'(r_dt));
                mul_b = BW'(r_err);
            end
            ST_MUL_P: begin
                mul_a = i_gain_p;
                mul_b = BW'(r_err);
            end
            ST_MUL_I: begin
                mul_a = i_gain_i;
                mul_b = BW'(r_integral);
            end
            ST_MUL_D: begin
                mul_a = i_gain_d;
                mul_b = BW'(r_rate);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE:    n_state = load_item ? ST_DIV : ST_IDLE;
            ST_DIV:     n_state = div_last ? ST_RATE : ST_DIV;
            ST_RATE:    n_state = r_do_int ? ST_MUL_INT : ST_MUL_P;
            ST_MUL_INT: n_state = mul_done ? ST_MUL_P : ST_MUL_INT;
            ST_MUL_P: begin
                if (mul_done) begin
                    n_state = r_inside ? ST_MUL_I : ST_MUL_D;
                end else begin
                    n_state = ST_MUL_P;
                end
            end
            ST_MUL_I:   n_state = mul_done ? ST_MUL_D : ST_MUL_I;
            ST_MUL_D:   n_state = mul_done ? ST_FINISH : ST_MUL_D;
            ST_FINISH:  n_state = ST_OUT;
            ST_OUT:     n_state = out_load ? ST_IDLE : ST_OUT;
            default:    n_state = ST_IDLE;
        endcase
    end

    pid_mulq #(
        .BW        (BW),
        .FRAC_BITS (FRAC_BITS)
    ) u_mulq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev_err  <= '0;
            r_integral  <= '0;
            r_prev_raw  <= '0;
        end else begin
            r_state <= n_state;
            if (mul_start) begin
                r_issued <= 1'b1;
            end else if (mul_done) begin
                r_issued <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_MUL_INT && mul_done) begin
                r_integral <= sat_acc(SUM_W'(r_integral) + SUM_W'(mul_res));
            end
            if (r_state == ST_FINISH) begin
                r_prev_raw <= sat_acc(r_acc);
                r_prev_err <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_item) begin
            r_err    <= i_err;
            r_dt     <= i_dt;
            r_inside <= in_band;
            r_do_int <= in_band && take;
            r_neg    <= derr[DERR_W-1];
            r_num    <= NWE'({dmag[NMAG_W-1:0], {FRAC_BITS{1'b0}}});
            r_rem    <= '0;
            r_cnt    <= '0;
        end
        if (r_state == ST_DIV) begin
            r_num <= {r_num[NWE-3:0], q_a, q_b};
            r_rem <= rem_b2[FRAC_BITS-1:0];
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (r_state == ST_RATE) begin
            r_rate <= rate;
        end
        if (mul_done) begin
            if (r_state == ST_MUL_P) begin
                r_acc <= SUM_W'(mul_res);
            end else if (r_state == ST_MUL_I || r_state == ST_MUL_D) begin
                r_acc <= r_acc + SUM_W'(mul_res);
            end
        end
        if (out_load) begin
            r_drive <= clamp_lo[DATA_WIDTH-1:0];
        end
    end

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_dt))
        else $error("divider remainder not below the time step");

    a_done_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_issued)
        else $error("multiplier result without a pending request");

    a_issued_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issued |-> (r_state == ST_MUL_INT || r_state == ST_MUL_P ||
                      r_state == ST_MUL_I || r_state == ST_MUL_D))
        else $error("multiplier request pending outside a multiply step");

endmodule

`default_nettype wire

@@ hdl/pid_integral_separation_antiwindup.sv @@
// Positional PID controller with integral separation and anti-windup.
// Input channel i_valid/o_ready carries setpoint, measured value and a
// millisecond stamp; output channel o_valid/i_ready carries the drive.
// Each transfer in yields exactly one transfer out, in order.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data, one
// register per cycle; the user must write it only while no item is in
// flight, as the block itself does not enforce this.
// The derivative divider retires two quotient bits a cycle, and one shared
// multiplier forms the products one after another. A blocked integral update
// skips the integral step product; an error outside the band skips both
// integral products. Items are processed one at a time, so the core takes no
// new item before it is through with the last one.
// An input stage and a two-entry queue hold further items while the core
// works, and a finished result waits in the output register when the
// receiver stalls; the core holds its next result until it is taken.
// Synchronous reset clears the gains and threshold, opens the limits to the
// full range, and zeroes the stamp, error, integral and output history.
// Depends on pid_pkg, pid_front, pid_fifo, pid_mulq and pid_core.
`default_nettype none

module pid_integral_separation_antiwindup
    import pid_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_setpoint,
    input  logic signed [DATA_WIDTH-1:0] i_measured,
    input  logic        [31:0]           i_stamp_ms,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_drive,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [((DATA_WIDTH > GAIN_W) ? DATA_WIDTH : GAIN_W)-1:0] i_cfg_data
);

    localparam int EW  = DATA_WIDTH + 1;
    localparam int QW  = EW + FRAC_BITS;

    logic signed [GAIN_W-1:0]     r_gain_p;
    logic signed [GAIN_W-1:0]     r_gain_i;
    logic signed [GAIN_W-1:0]     r_gain_d;
    logic        [THR_W-1:0]      r_sep_thr;
    logic signed [DATA_WIDTH-1:0] r_limit_high;
    logic signed [DATA_WIDTH-1:0] r_limit_low;

    t_queue_status                queue_status;
    logic                         push;
    logic                         pop;
    logic signed [EW-1:0]         front_err;
    logic        [FRAC_BITS-1:0]  front_dt;
    logic        [QW-1:0]         queue_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_sep_thr    <= '0;
            r_limit_high <= signed'({1'b0, {(DATA_WIDTH-1){1'b1}}});
            r_limit_low  <= signed'({1'b1, {(DATA_WIDTH-1){1'b0}}});
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAIN_P:     r_gain_p     <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:     r_gain_i     <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:     r_gain_d     <= i_cfg_data[GAIN_W-1:0];
                CFG_SEP_THR:    r_sep_thr    <= i_cfg_data[THR_W-1:0];
                CFG_LIMIT_HIGH: r_limit_high <= i_cfg_data[DATA_WIDTH-1:0];
                CFG_LIMIT_LOW:  r_limit_low  <= i_cfg_data[DATA_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    pid_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_setpoint (i_setpoint),
        .i_measured (i_measured),
        .i_stamp_ms (i_stamp_ms),
        .i_queue    (queue_status),
        .o_push     (push),
        .o_err      (front_err),
        .o_dt       (front_dt)
    );

    pid_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   ({front_err, front_dt}),
        .i_pop    (pop),
        .o_data   (queue_rd),
        .o_status (queue_status)
    );

    pid_core #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_queue      (queue_status),
        .i_err        (queue_rd[QW-1:FRAC_BITS]),
        .i_dt         (queue_rd[FRAC_BITS-1:0]),
        .o_pop        (pop),
        .i_gain_p     (r_gain_p),
        .i_gain_i     (r_gain_i),
        .i_gain_d     (r_gain_d),
        .i_sep_thr    (r_sep_thr),
        .i_limit_high (r_limit_high),
        .i_limit_low  (r_limit_low),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_drive      (o_drive)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for pid_integral_separation_antiwindup.
// Holds its own fixed-point PID predictor and a small scoreboard class;
// depends only on pid_pkg and the top module of the block.
`timescale 1ns / 100ps

module tb;
    import pid_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int CW = 32;
    localparam int STALL_LIMIT = 20000;
    localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint MS_K = ((64'd1 << (FB + MS_SHIFT)) + 500) / 1000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [DW-1:0] i_setpoint = '0;
    logic signed [DW-1:0] i_measured = '0;
    logic [31:0] i_stamp_ms = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [DW-1:0] o_drive;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_GAIN_P;
    logic [CW-1:0] i_cfg_data = '0;

    pid_integral_separation_antiwindup u_dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Controller state as the predictor sees it.
    longint kp, ki, kd, sep_thr, lim_hi, lim_lo;
    logic [31:0] last_stamp;
    longint last_err, integ, last_raw;

    int fail_count = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int idle_count = 0;
    int sent_count = 0;
    int recv_count = 0;

    task automatic report(input string what);
        fail_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    function automatic longint clamp_acc(input longint v);
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    // floor(a*b / 2^FB) saturated to the accumulator width, via 128-bit product.
    function automatic longint scale_mul(input longint a, input longint b);
        logic signed [127:0] p;
        p = ($signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b})) >>> FB;
        if (p > ACC_HI) return ACC_HI;
        if (p < ACC_LO) return ACC_LO;
        return longint'(p);
    endfunction

    function automatic logic [DW-1:0] predict_drive(input logic signed [DW-1:0] sp,
                                                    input logic signed [DW-1:0] mv,
                                                    input logic [31:0] stamp);
        longint err, dms, dtq, aerr, derr, q, r, rate, qlim, pt, it, dt, raw, drv;
        logic [31:0] diff;
        bit in_band, take;
        err = longint'(sp) - longint'(mv);
        diff = stamp - last_stamp;
        dms = longint'($signed(diff));
        if (dms < DT_MIN_MS) dms = DT_MIN_MS;
        if (dms > DT_MAX_MS) dms = DT_MAX_MS;
        dtq = (dms * MS_K + (64'sd1 << (MS_SHIFT - 1))) >>> MS_SHIFT;
        if (dtq < 1) dtq = 1;
        aerr = err < 0 ? -err : err;
        in_band = aerr < sep_thr;
        if (in_band) begin
            if (last_raw >= lim_hi) take = err < 0;
            else if (last_raw <= lim_lo) take = err > 0;
            else take = 1'b1;
            if (take) integ = clamp_acc(integ + scale_mul(dtq, err));
        end
        derr = err - last_err;
        q = derr / dtq;
        r = derr % dtq;
        qlim = (64'sd1 << (ACC_W - 1)) >>> FB;
        if (q >= qlim) rate = ACC_HI;
        else if (q <= -qlim) rate = ACC_LO;
        else rate = clamp_acc(q * (64'sd1 << FB) + (r * (64'sd1 << FB)) / dtq);
        pt = scale_mul(kp, err);
        it = in_band ? scale_mul(ki, integ) : 0;
        dt = scale_mul(kd, rate);
        raw = clamp_acc(pt + it + dt);
        last_stamp = stamp;
        last_err = err;
        last_raw = raw;
        drv = raw;
        if (drv > lim_hi) drv = lim_hi;
        if (drv < lim_lo) drv = lim_lo;
        return drv[DW-1:0];
    endfunction

    class drive_board;
        logic [DW-1:0] pending[$];

        function void note_input(logic signed [DW-1:0] sp, logic signed [DW-1:0] mv,
                                 logic [31:0] st);
            pending.push_back(predict_drive(sp, mv, st));
        endfunction

        task check_drive(logic [DW-1:0] got);
            logic [DW-1:0] want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected drive %h", got));
                return;
            end
            want = pending.pop_front();
            if (got !== want) report($sformatf("drive got %h want %h", got, want));
        endtask
    endclass

    drive_board board = new();

    // Monitor, receiver-side stall and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                board.note_input(i_setpoint, i_measured, i_stamp_ms);
                sent_count++;
            end
            if (o_valid && i_ready) begin
                board.check_drive(o_drive);
                recv_count++;
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_count <= 0;
            else idle_count <= idle_count + 1;
            if (idle_count > STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
        i_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    task automatic write_reg(input t_cfg_index idx, input logic [CW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GAIN_P: kp = longint'($signed(val));
            CFG_GAIN_I: ki = longint'($signed(val));
            CFG_GAIN_D: kd = longint'($signed(val));
            CFG_SEP_THR: sep_thr = longint'(val[THR_W-1:0]);
            CFG_LIMIT_HIGH: lim_hi = longint'($signed(val));
            default: lim_lo = longint'($signed(val));
        endcase
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Valid stays up after a transfer only until the next sample or idle
    // cycle replaces it in the same time step.
    task automatic send_sample(input logic [DW-1:0] sp, input logic [DW-1:0] mv,
                               input logic [31:0] st);
        while ($urandom_range(99) < in_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_setpoint <= sp;
        i_measured <= mv;
        i_stamp_ms <= st;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    function automatic logic [DW-1:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(8191) - 4096;
            2: return ($urandom_range(255) << 12) - (128 << 12);
            default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    task automatic random_gains(input bit wide);
        write_reg(CFG_GAIN_P, wide ? $urandom() : $urandom_range(131071) - 65536);
        write_reg(CFG_GAIN_I, wide ? $urandom() : $urandom_range(32767) - 16384);
        write_reg(CFG_GAIN_D, wide ? $urandom() : $urandom_range(8191) - 4096);
        write_reg(CFG_SEP_THR, $urandom_range(3) == 0 ? $urandom() : $urandom_range(1 << 22));
        write_reg(CFG_LIMIT_HIGH, $urandom_range(3) == 0 ? 32'h7fffffff : $urandom_range(1 << 24));
        write_reg(CFG_LIMIT_LOW, $urandom_range(7) == 0 ? $urandom_range(1 << 20)
                                                        : -$urandom_range(1 << 24));
    endtask

    initial begin
        logic [31:0] stamp;
        kp = 0; ki = 0; kd = 0; sep_thr = 0;
        lim_hi = 64'sd2147483647; lim_lo = -64'sd2147483648;
        last_stamp = '0; last_err = 0; integ = 0; last_raw = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset gains, then extremes, backward stamps, wrap, limits.
        in_idle_pct = 26; out_idle_pct = 87;
        send_sample(32'h7fffffff, 32'h80000000, 32'd0);
        drain();
        write_reg(CFG_GAIN_P, 32'h0001_0000);
        write_reg(CFG_GAIN_I, 32'h7fffffff);
        write_reg(CFG_GAIN_D, 32'h80000000);
        write_reg(CFG_SEP_THR, 32'h7fffffff);
        write_reg(CFG_LIMIT_HIGH, 32'h0010_0000);
        write_reg(CFG_LIMIT_LOW, 32'hfff0_0000);
        send_sample(32'h80000000, 32'h7fffffff, 32'd5);
        send_sample(32'h7fffffff, 32'h80000000, 32'd3);
        send_sample(32'h0001_0000, 32'h0, 32'd1000);
        send_sample(32'h0, 32'h0001_0000, 32'hffff_fff0);
        send_sample(32'h0000_8000, 32'h0, 32'd4);
        send_sample(32'hffff_0000, 32'h0, 32'd100);
        send_sample(32'h0, 32'h0, 32'd600);
        send_sample(32'h0, 32'hffffffff, 32'h8000_0000);
        drain();
        write_reg(CFG_GAIN_I, 32'h0000_4000);
        write_reg(CFG_SEP_THR, 32'h0);
        write_reg(CFG_LIMIT_HIGH, 32'hffff_0000);
        write_reg(CFG_LIMIT_LOW, 32'h0001_0000);
        send_sample(32'h0002_0000, 32'h0, 32'h8000_0010);
        send_sample(32'h0, 32'h0002_0000, 32'h8000_0100);
        drain();
        write_reg(CFG_SEP_THR, 32'h0100_0000);
        write_reg(CFG_LIMIT_HIGH, 32'h0000_0000);
        write_reg(CFG_LIMIT_LOW, 32'h80000000);
        send_sample(32'h0004_0000, 32'h0, 32'h8000_0200);
        send_sample(32'h0, 32'h0004_0000, 32'h8000_0300);
        send_sample(32'hfff0_0000, 32'h0, 32'h8000_0400);
        drain();

        stamp = 32'h8000_0400;
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 0) begin in_idle_pct = 26; out_idle_pct = 87; end
            else if (ph == 1) begin in_idle_pct = 87; out_idle_pct = 26; end
            else begin in_idle_pct = 0; out_idle_pct = 0; end
            for (int blk = 0; blk < 4; blk++) begin
                random_gains(blk == 3);
                for (int n = 0; n < 52; n++) begin
                    case ($urandom_range(9))
                        0: stamp = $urandom();
                        1: stamp = stamp - $urandom_range(100);
                        default: stamp = stamp + $urandom_range(10, 500);
                    endcase
                    send_sample(rand_value(), rand_value(), stamp);
                end
                // The sender holds off until every expected drive is back.
                drain();
            end
        end

        $display("covered %0d samples in, %0d drives out, over directed limits,",
                 sent_count, recv_count);
        $display("  backward and wrapped stamps, and three stall patterns");
        if (fail_count == 0 && board.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

@@ files.f @@
hdl/pid_pkg.sv
hdl/pid_front.sv
hdl/pid_fifo.sv
hdl/pid_mulq.sv
hdl/pid_core.sv
hdl/pid_integral_separation_antiwindup.sv
tb/sv/tb.sv
